FILE: rtl/core/psro_pkg.sv
package psro_pkg;

    // Fixed-point formats
    localparam int TrigFracBitsDef = 15;
    localparam int ScaleFracBits   = 8;

    // Degree landmarks
    localparam logic [8:0] DegQuarter   = 9'd90;
    localparam logic [8:0] DegHalf      = 9'd180;
    localparam logic [8:0] DegThreeQtr  = 9'd270;
    localparam logic [8:0] DegFull      = 9'd360;
    localparam int         DegHalfTurn  = 180;

    // pi in Q30
    localparam logic [63:0] PiQ30 = 64'hC90F_DAA2;

    // Taylor divisors (2k)(2k+1), k = 1..12
    localparam logic [9:0] TaylorDiv [12] = '{
        10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156,
        10'd210, 10'd272, 10'd342, 10'd420, 10'd506, 10'd600
    };

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_SCALE   = 3'd0,
        CFG_TILT_X  = 3'd1,
        CFG_TILT_Y  = 3'd2,
        CFG_TILT_Z  = 3'd3,
        CFG_SHIFT_X = 3'd4,
        CFG_SHIFT_Y = 3'd5
    } t_cfg_idx;

    localparam logic [15:0] ScaleReset = 16'd256;

    // Enables of a two-register pipeline section
    typedef struct packed {
        logic en_a;
        logic en_b;
    } t_stg_ctl;

    // sin of deg (0..90) as unsigned value with frac fraction bits.
    // Only evaluated at elaboration to build the lookup table.
    function automatic logic [63:0] sin_quadrant(input int unsigned deg,
                                                 input int unsigned frac);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (64'(deg) * PiQ30 + 64'(DegHalfTurn / 2)) / DegHalfTurn;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * x2) >> 30) / TaylorDiv[k-1];
            if (k % 2 == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        r = ((sum >> (29 - frac)) + 64'd1) >> 1;
        if (r > (64'd1 << frac)) begin
            r = 64'd1 << frac;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/point_scale_rotate_offset_top.sv
// Scales each 3D point by an unsigned Q8.8 factor, rotates it about X, Y and Z by whole-degree
// angles and adds screen offsets to x and y. One point per clock unless the output stalls.
// Registered in turn: the scale product, the scaled point, for each of the three rotations
// the four products and then their sums rounded toward zero, and the offset add into the
// output register. Stages only hold when the stage ahead is full and stalled, so gaps close
// up under backpressure. Sine and cosine come from a 91-entry quarter-wave table and are
// registered from the angle registers; a configuration write also affects points already in
// the pipeline. Configuration writes are always accepted; indexes 6 and 7 are ignored.
module point_scale_rotate_offset_top import psro_pkg::*; #(
    parameter int TRIG_FRAC_BITS = TrigFracBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // in_x, in_y, in_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // out_x, out_y, out_z
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int NStg = 9;
    localparam int TW   = TRIG_FRAC_BITS + 2;

    logic [15:0]        r_scale;
    logic [8:0]         r_tilt [3];
    logic signed [15:0] r_shift_x;
    logic signed [15:0] r_shift_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= ScaleReset;
            r_tilt[0] <= '0;
            r_tilt[1] <= '0;
            r_tilt[2] <= '0;
            r_shift_x <= '0;
            r_shift_y <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SCALE:   r_scale   <= i_cfg_data;
                CFG_TILT_X:  r_tilt[0] <= i_cfg_data[8:0];
                CFG_TILT_Y:  r_tilt[1] <= i_cfg_data[8:0];
                CFG_TILT_Z:  r_tilt[2] <= i_cfg_data[8:0];
                CFG_SHIFT_X: r_shift_x <= i_cfg_data;
                CFG_SHIFT_Y: r_shift_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage control: a stage loads when empty or when the next one loads
    logic [NStg-1:0] r_vld;
    logic [NStg-1:0] w_en;
    logic [NStg-1:0] n_vld;

    always_comb begin
        w_en[NStg-1] = !r_vld[NStg-1] || m_axis_tready;
        for (int k = NStg - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld = {r_vld[NStg-2:0], s_axis_tvalid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NStg; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_vld[NStg-1];

    // Trig values per axis
    logic signed [TW-1:0] w_sin [3];
    logic signed [TW-1:0] w_cos [3];

    for (genvar a = 0; a < 3; a++) begin : g_trig
        psro_trig #(
            .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
        ) u_trig (
            .i_clk   (i_clk),
            .i_angle (r_tilt[a]),
            .o_sin   (w_sin[a]),
            .o_cos   (w_cos[a])
        );
    end

    // Scale
    logic signed [15:0] w_in [3];
    logic signed [31:0] w_sc [3];
    t_stg_ctl           w_ctl [4];

    assign w_in[0] = s_axis_tdata[15:0];
    assign w_in[1] = s_axis_tdata[31:16];
    assign w_in[2] = s_axis_tdata[47:32];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_ctl[i].en_a = w_en[2*i];
            w_ctl[i].en_b = w_en[2*i+1];
        end
    end

    psro_scale u_scale (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl[0]),
        .i_v     (w_in),
        .i_scale (r_scale),
        .o_v     (w_sc)
    );

    // Rotate about X: (p, q, w) = (y, z, x)
    logic signed [31:0] w_x1, w_y1, w_z1;

    psro_rotate #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_rot_x (
        .i_clk (i_clk),
        .i_ctl (w_ctl[1]),
        .i_sin (w_sin[0]),
        .i_cos (w_cos[0]),
        .i_p   (w_sc[1]),
        .i_q   (w_sc[2]),
        .i_w   (w_sc[0]),
        .o_p   (w_y1),
        .o_q   (w_z1),
        .o_w   (w_x1)
    );

    // Rotate about Y: (p, q, w) = (z, x, y)
    logic signed [31:0] w_x2, w_y2, w_z2;

    psro_rotate #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_rot_y (
        .i_clk (i_clk),
        .i_ctl (w_ctl[2]),
        .i_sin (w_sin[1]),
        .i_cos (w_cos[1]),
        .i_p   (w_z1),
        .i_q   (w_x1),
        .i_w   (w_y1),
        .o_p   (w_z2),
        .o_q   (w_x2),
        .o_w   (w_y2)
    );

    // Rotate about Z: (p, q, w) = (x, y, z)
    logic signed [31:0] w_x3, w_y3, w_z3;

    psro_rotate #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_rot_z (
        .i_clk (i_clk),
        .i_ctl (w_ctl[3]),
        .i_sin (w_sin[2]),
        .i_cos (w_cos[2]),
        .i_p   (w_x2),
        .i_q   (w_y2),
        .i_w   (w_z2),
        .o_p   (w_x3),
        .o_q   (w_y3),
        .o_w   (w_z3)
    );

    // Offset and output register
    logic signed [31:0] r_out_x, r_out_y, r_out_z;

    always_ff @(posedge i_clk) begin
        if (w_en[NStg-1]) begin
            r_out_x <= w_x3 + 32'(r_shift_x);
            r_out_y <= w_y3 + 32'(r_shift_y);
            r_out_z <= w_z3;
        end
    end

    assign m_axis_tdata = {r_out_z, r_out_y, r_out_x};

endmodule

FILE: rtl/core/psro_trig.sv
module psro_trig import psro_pkg::*; #(
    parameter int TRIG_FRAC_BITS = TrigFracBitsDef
) (
    input  logic                             i_clk,
    input  logic [8:0]                       i_angle,
    output logic signed [TRIG_FRAC_BITS+1:0] o_sin,
    output logic signed [TRIG_FRAC_BITS+1:0] o_cos
);

    localparam int TW = TRIG_FRAC_BITS + 2;

    typedef struct packed {
        logic       neg;
        logic [6:0] idx;
    } t_tab_sel;

    logic [TRIG_FRAC_BITS:0] w_tab [0:90];

    for (genvar g = 0; g <= 90; g++) begin : g_tab
        localparam logic [63:0] Val = sin_quadrant(g, TRIG_FRAC_BITS);
        assign w_tab[g] = Val[TRIG_FRAC_BITS:0];
    end

    // fold an angle in 0..359 onto the first quadrant
    function automatic t_tab_sel fold(input logic [8:0] a);
        t_tab_sel   s;
        logic [8:0] d;
        if (a < DegQuarter) begin
            s.neg = 1'b0;
            d     = a;
        end else if (a < DegHalf) begin
            s.neg = 1'b0;
            d     = DegHalf - a;
        end else if (a < DegThreeQtr) begin
            s.neg = 1'b1;
            d     = a - DegHalf;
        end else begin
            s.neg = 1'b1;
            d     = DegFull - a;
        end
        s.idx = d[6:0];
        return s;
    endfunction

    logic [8:0]               w_a;
    logic [8:0]               w_b;
    t_tab_sel                 w_sel_s;
    t_tab_sel                 w_sel_c;
    logic signed [TW-1:0]     w_mag_s;
    logic signed [TW-1:0]     w_mag_c;
    logic signed [TW-1:0]     n_sin;
    logic signed [TW-1:0]     n_cos;
    logic signed [TW-1:0]     r_sin;
    logic signed [TW-1:0]     r_cos;

    always_comb begin
        w_a = (i_angle >= DegFull) ? i_angle - DegFull : i_angle;
        w_b = w_a + DegQuarter;
        if (w_b >= DegFull) begin
            w_b = w_b - DegFull;
        end
        w_sel_s = fold(w_a);
        w_sel_c = fold(w_b);
        w_mag_s = $signed({1'b0, w_tab[w_sel_s.idx]});
        w_mag_c = $signed({1'b0, w_tab[w_sel_c.idx]});
        n_sin   = w_sel_s.neg ? -w_mag_s : w_mag_s;
        n_cos   = w_sel_c.neg ? -w_mag_c : w_mag_c;
    end

    always_ff @(posedge i_clk) begin
        r_sin <= n_sin;
        r_cos <= n_cos;
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

FILE: rtl/core/psro_scale.sv
module psro_scale import psro_pkg::*; (
    input  logic               i_clk,
    input  t_stg_ctl           i_ctl,
    input  logic signed [15:0] i_v [3],
    input  logic [15:0]        i_scale,
    output logic signed [31:0] o_v [3]
);

    localparam logic signed [33:0] Bias = 34'((1 << ScaleFracBits) - 1);

    logic signed [32:0] r_prod [3];
    logic signed [31:0] r_v    [3];
    logic signed [33:0] n_sum  [3];
    logic signed [33:0] n_sh   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // round toward zero: bias negatives before the shift
            n_sum[i] = 34'(r_prod[i]) + (r_prod[i][32] ? Bias : 34'sd0);
            n_sh[i]  = n_sum[i] >>> ScaleFracBits;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (i_ctl.en_a) begin
                r_prod[i] <= 33'(i_v[i]) * 33'($signed({1'b0, i_scale}));
            end
            if (i_ctl.en_b) begin
                r_v[i] <= n_sh[i][31:0];
            end
        end
    end

    assign o_v = r_v;

endmodule

FILE: rtl/core/psro_rotate.sv
// p' = trunc((p*c - q*s) / 2^F), q' = trunc((p*s + q*c) / 2^F), w passes along
module psro_rotate import psro_pkg::*; #(
    parameter int TRIG_FRAC_BITS = TrigFracBitsDef
) (
    input  logic                             i_clk,
    input  t_stg_ctl                         i_ctl,
    input  logic signed [TRIG_FRAC_BITS+1:0] i_sin,
    input  logic signed [TRIG_FRAC_BITS+1:0] i_cos,
    input  logic signed [31:0]               i_p,
    input  logic signed [31:0]               i_q,
    input  logic signed [31:0]               i_w,
    output logic signed [31:0]               o_p,
    output logic signed [31:0]               o_q,
    output logic signed [31:0]               o_w
);

    localparam int PW = 32 + TRIG_FRAC_BITS + 2;
    localparam logic signed [PW:0] Bias = (PW+1)'((1 << TRIG_FRAC_BITS) - 1);

    logic signed [PW-1:0] r_pc;
    logic signed [PW-1:0] r_qs;
    logic signed [PW-1:0] r_ps;
    logic signed [PW-1:0] r_qc;
    logic signed [31:0]   r_w_a;
    logic signed [31:0]   r_p;
    logic signed [31:0]   r_q;
    logic signed [31:0]   r_w;
    logic signed [PW:0]   n_dp;
    logic signed [PW:0]   n_dq;
    logic signed [PW:0]   n_sp;
    logic signed [PW:0]   n_sq;

    always_comb begin
        n_dp = (PW+1)'(r_pc) - (PW+1)'(r_qs);
        n_dq = (PW+1)'(r_ps) + (PW+1)'(r_qc);
        n_sp = (n_dp + (n_dp[PW] ? Bias : '0)) >>> TRIG_FRAC_BITS;
        n_sq = (n_dq + (n_dq[PW] ? Bias : '0)) >>> TRIG_FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_pc  <= PW'(i_p) * PW'(i_cos);
            r_qs  <= PW'(i_q) * PW'(i_sin);
            r_ps  <= PW'(i_p) * PW'(i_sin);
            r_qc  <= PW'(i_q) * PW'(i_cos);
            r_w_a <= i_w;
        end
        if (i_ctl.en_b) begin
            r_p <= n_sp[31:0];
            r_q <= n_sq[31:0];
            r_w <= r_w_a;
        end
    end

    assign o_p = r_p;
    assign o_q = r_q;
    assign o_w = r_w;

endmodule
